// File: src/lkvt_pkg.sv
// Package for the linear key/value table: sizes, request codes, payload and state types.
package lkvt_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int REQ_W      = 3;
  localparam int POS_W      = 4;
  localparam int CAP_W      = 5;

  localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_OR_UPD = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ERASE      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LOOKUP     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ_AT    = 3'd5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [KEY_BITS-1:0]   key_in;
    logic [VALUE_BITS-1:0] value_in;
    logic [POS_W-1:0]      position;
  } in_t;

  typedef struct packed {
    logic                  ok;
    logic [KEY_BITS-1:0]   key_out;
    logic [VALUE_BITS-1:0] value_out;
    logic [CNT_W-1:0]      entry_total;
    logic                  is_empty;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_READ,
    ST_RWAIT,
    ST_FIN
  } state_t;

endpackage

// File: src/linear_key_value_table_top.sv
// Top level of the linear key/value table: sequencer, entry memories and result register.
// Sequencing: insert, update, insert_or_update and lookup scan the held entries in order,
//   one key compare per cycle, then register the result. Erase on a match then moves each
//   later entry down one place, and read_at reads the given position; the single memory
//   read port sets this pace.
// Throughput: one item at a time; the next item is accepted once the result is registered.
// Reset (synchronous, rst_n low): count 0, limit 16, no result; memories kept, read below count.
module linear_key_value_table_top
  import lkvt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data
);

  // Entry memories: one write port, one registered read port each.
  logic [KEY_BITS-1:0]   key_mem   [DEPTH];
  logic [VALUE_BITS-1:0] value_mem [DEPTH];

  state_t state_r, state_nxt;

  // Request held for the duration of the item.
  logic [REQ_W-1:0]      req_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [POS_W-1:0]      pos_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;

  // Scan / shift pipeline: issue index, then compare or write in the next cycle.
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;

  // Result being built.
  logic                  res_ok_r, res_ok_nxt;
  logic [KEY_BITS-1:0]   res_key_r, res_key_nxt;
  logic [VALUE_BITS-1:0] res_val_r, res_val_nxt;

  // Memory ports.
  logic [IDX_W-1:0]      rd_addr;
  logic [KEY_BITS-1:0]   rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  logic                  wk_en, wv_en;
  logic [IDX_W-1:0]      waddr;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wval;

  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r;
  logic       out_load;

  logic             in_accept;
  logic [CNT_W-1:0] limit;
  logic             has_room;
  logic             hit, miss;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp the capacity limit to the built depth.
  assign limit    = (int'(cap_r) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(cap_r);
  assign has_room = count_r < limit;

  // Search outcome: a match on the compared entry, or a miss when the table is empty or the last held entry failed.
  assign hit  = cmp_vld_r && (rd_key_r == key_r);
  assign miss = (count_r == '0) ||
                (cmp_vld_r && (rd_key_r != key_r) &&
                 ({1'b0, cmp_idx_r} == CNT_W'(count_r - CNT_W'(1))));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    res_ok_nxt    = res_ok_r;
    res_key_nxt   = res_key_r;
    res_val_nxt   = res_val_r;
    rd_addr       = issue_r[IDX_W-1:0];
    wk_en         = 1'b0;
    wv_en         = 1'b0;
    waddr         = count_r[IDX_W-1:0];
    wkey          = key_r;
    wval          = val_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_ok_nxt  = 1'b0;
          res_key_nxt = '0;
          res_val_nxt = '0;
          issue_nxt   = '0;
          priority if (in_data.req_type == REQ_READ_AT) begin
            state_nxt = ST_READ;
          end else if (in_data.req_type == REQ_INSERT || in_data.req_type == REQ_UPDATE ||
                       in_data.req_type == REQ_INS_OR_UPD || in_data.req_type == REQ_ERASE ||
                       in_data.req_type == REQ_LOOKUP) begin
            state_nxt = ST_SCAN;
          end else begin
            // Unused codes: no operation.
            state_nxt = ST_FIN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next held entry while comparing the previous one.
        if (issue_r < count_r) begin
          rd_addr     = issue_r[IDX_W-1:0];
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = CNT_W'(issue_r + CNT_W'(1));
        end
        if (hit || miss) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_FIN;
          unique case (req_r)
            REQ_INSERT: begin
              if (miss && has_room) begin
                wk_en      = 1'b1;
                wv_en      = 1'b1;
                waddr      = count_r[IDX_W-1:0];
                count_nxt  = CNT_W'(count_r + CNT_W'(1));
                res_ok_nxt = 1'b1;
              end
            end
            REQ_UPDATE: begin
              if (hit) begin
                wv_en      = 1'b1;
                waddr      = cmp_idx_r;
                res_ok_nxt = 1'b1;
              end
            end
            REQ_INS_OR_UPD: begin
              if (hit) begin
                wv_en      = 1'b1;
                waddr      = cmp_idx_r;
                res_ok_nxt = 1'b1;
              end else if (has_room) begin
                wk_en      = 1'b1;
                wv_en      = 1'b1;
                waddr      = count_r[IDX_W-1:0];
                count_nxt  = CNT_W'(count_r + CNT_W'(1));
                res_ok_nxt = 1'b1;
              end
            end
            REQ_ERASE: begin
              if (hit) begin
                // Move later entries down, starting with the one after the match.
                res_ok_nxt = 1'b1;
                issue_nxt  = CNT_W'({1'b0, cmp_idx_r} + CNT_W'(1));
                state_nxt  = ST_SHIFT;
              end
            end
            REQ_LOOKUP: begin
              if (hit) begin
                res_ok_nxt  = 1'b1;
                res_val_nxt = rd_val_r;
              end
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // Write back the entry read last cycle one place lower.
        wk_en = pend_r;
        wv_en = pend_r;
        waddr = pend_addr_r;
        wkey  = rd_key_r;
        wval  = rd_val_r;
        if (issue_r < count_r) begin
          rd_addr       = issue_r[IDX_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = IDX_W'(issue_r[IDX_W-1:0] - IDX_W'(1));
          issue_nxt     = CNT_W'(issue_r + CNT_W'(1));
        end else if (!pend_r) begin
          count_nxt = CNT_W'(count_r - CNT_W'(1));
          state_nxt = ST_FIN;
        end
      end

      ST_READ: begin
        rd_addr   = pos_r;
        state_nxt = ST_RWAIT;
      end

      ST_RWAIT: begin
        if ({1'b0, pos_r} < count_r) begin
          res_ok_nxt  = 1'b1;
          res_key_nxt = rd_key_r;
          res_val_nxt = rd_val_r;
        end
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      cmp_vld_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    issue_r     <= issue_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_ok_r    <= res_ok_nxt;
    res_key_r   <= res_key_nxt;
    res_val_r   <= res_val_nxt;
    if (in_accept) begin
      req_r <= in_data.req_type;
      key_r <= in_data.key_in;
      val_r <= in_data.value_in;
      pos_r <= in_data.position;
    end
    if (out_load) begin
      out_data_r.ok          <= res_ok_r;
      out_data_r.key_out     <= res_key_r;
      out_data_r.value_out   <= res_val_r;
      out_data_r.entry_total <= count_r;
      out_data_r.is_empty    <= (count_r == '0);
    end
  end

  // Entry memories.
  always_ff @(posedge clk) begin
    if (wk_en) begin
      key_mem[waddr] <= wkey;
    end
    if (wv_en) begin
      value_mem[waddr] <= wval;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= value_mem[rd_addr];
  end

  // Count never passes the built depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // Count moves by at most one per item step.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == CNT_W'($past(count_r) + CNT_W'(1)) ||
       count_r == CNT_W'($past(count_r) - CNT_W'(1))))
    else $error("entry count jumped");

  // Memories are written only while searching or shifting.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    (wk_en || wv_en) |-> (state_r == ST_SCAN || state_r == ST_SHIFT))
    else $error("memory write outside scan or shift");

  // A shift write lands below the last held entry.
  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && wk_en) |-> (CNT_W'({1'b0, waddr} + CNT_W'(1)) < count_r))
    else $error("shift write out of range");

  // An accepted item leaves idle on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != ST_IDLE))
    else $error("idle after accept");

endmodule

// File: test/tb_linear_key_value_table_top.sv
// Testbench for the linear key/value table: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_linear_key_value_table_top;
  import lkvt_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 1_000_000;
  // Worst request is an erase at the front of a full table.
  localparam int SETTLE_CYCLES   = 3 * DEPTH;
  localparam int KEY_POOL_SIZE   = 24;
  localparam int ITEMS_PER_PHASE = 360;
  localparam int MAX_PRINTED     = 100;

  // Request codes the block treats as no operation.
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam logic [KEY_BITS-1:0]   KEY_ONES = '1;
  localparam logic [VALUE_BITS-1:0] VAL_ONES = '1;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_data  = '0;

  // Shadow copy of the table, advanced once per accepted item.
  logic [KEY_BITS-1:0]   shadow_keys [DEPTH];
  logic [VALUE_BITS-1:0] shadow_vals [DEPTH];
  int                    shadow_count;
  logic [CAP_W-1:0]      shadow_cap;

  out_t expected_results[$];

  logic [KEY_BITS-1:0] key_pool [KEY_POOL_SIZE];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int error_count    = 0;
  int cycle_count    = 0;
  int results_seen   = 0;
  int cap_writes     = 0;
  int ops_sent [8];

  linear_key_value_table_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle from the current stall rate.
  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Print one line per mismatch (up to a cap, so a broken block cannot flood the log).
  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED)
      $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Position of a held key, or -1 when absent.
  function automatic int find_slot(input logic [KEY_BITS-1:0] key);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_keys[i] == key)
        return i;
    return -1;
  endfunction

  // Append a new pair unless the table is at its limit or the key is already held.
  function automatic bit try_insert(input in_t req, input int slot);
    int limit;
    limit = (shadow_cap < DEPTH) ? int'(shadow_cap) : DEPTH;
    if (shadow_count >= limit || slot >= 0)
      return 1'b0;
    shadow_keys[shadow_count] = req.key_in;
    shadow_vals[shadow_count] = req.value_in;
    shadow_count++;
    return 1'b1;
  endfunction

  // Apply one request to the shadow table and return the result the block must give.
  function automatic out_t apply_request(input in_t req);
    out_t res;
    int   slot;
    res  = '0;
    slot = find_slot(req.key_in);
    case (req.req_type)
      REQ_INSERT: res.ok = try_insert(req, slot);
      REQ_UPDATE: begin
        if (slot >= 0) begin
          shadow_vals[slot] = req.value_in;
          res.ok = 1'b1;
        end
      end
      REQ_INS_OR_UPD: begin
        if (slot >= 0) begin
          shadow_vals[slot] = req.value_in;
          res.ok = 1'b1;
        end else begin
          res.ok = try_insert(req, slot);
        end
      end
      REQ_ERASE: begin
        if (slot >= 0) begin
          // close the gap: every later entry moves down one place
          for (int i = slot; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_vals[i] = shadow_vals[i + 1];
          end
          shadow_count--;
          res.ok = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        if (slot >= 0) begin
          res.ok        = 1'b1;
          res.value_out = shadow_vals[slot];
        end
      end
      REQ_READ_AT: begin
        if (int'(req.position) < shadow_count) begin
          res.ok        = 1'b1;
          res.key_out   = shadow_keys[req.position];
          res.value_out = shadow_vals[req.position];
        end
      end
      default: ;
    endcase
    res.entry_total = CNT_W'(shadow_count);
    res.is_empty    = (shadow_count == 0);
    return res;
  endfunction

  function automatic in_t make_item(input logic [REQ_W-1:0] op,
                                    input logic [KEY_BITS-1:0] key,
                                    input logic [VALUE_BITS-1:0] val,
                                    input logic [POS_W-1:0] pos);
    in_t item;
    item.req_type = op;
    item.key_in   = key;
    item.value_in = val;
    item.position = pos;
    return item;
  endfunction

  // Mostly well-formed requests on a small key pool so keys recur; a few noise items.
  function automatic in_t random_request();
    in_t req;
    int  pick;
    req.key_in   = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    req.value_in = $urandom;
    req.position = POS_W'($urandom);
    pick         = $urandom_range(99);
    if (pick < 6) begin
      req.req_type = REQ_W'($urandom);
      req.key_in   = $urandom;
    end else if (pick < 30) req.req_type = REQ_INSERT;
    else if (pick < 42)     req.req_type = REQ_UPDATE;
    else if (pick < 60)     req.req_type = REQ_INS_OR_UPD;
    else if (pick < 78)     req.req_type = REQ_ERASE;
    else if (pick < 90)     req.req_type = REQ_LOOKUP;
    else                    req.req_type = REQ_READ_AT;
    return req;
  endfunction

  task automatic refill_key_pool();
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    for (int i = 2; i < KEY_POOL_SIZE; i++)
      key_pool[i] = $urandom;
  endtask

  // Send one item: called at a falling edge, returns at the falling edge after acceptance.
  // Valid is left high so a back-to-back item never toggles it within one step.
  task automatic send_request(input in_t req);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      if (in_valid) in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(apply_request(req));
    ops_sent[req.req_type]++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Write the capacity register while the block is idle.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    shadow_cap = cap;
    cap_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Every operation on its success path and all but insert_or_update on a failure path; extreme keys and values.
  task automatic test_basic_ops();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_capacity(CAP_RESET);
    send_request(make_item(REQ_INSERT,     '0,        '0,           '0));
    send_request(make_item(REQ_INSERT,     KEY_ONES,  VAL_ONES,     '1));
    send_request(make_item(REQ_INSERT,     '0,        32'h5555_AAAA, '0));  // present key
    send_request(make_item(REQ_UPDATE,     '0,        32'h1234_5678, '0));
    send_request(make_item(REQ_UPDATE,     32'd5,     32'hDEAD_BEEF, '0));  // absent key
    send_request(make_item(REQ_INS_OR_UPD, KEY_ONES,  32'hA5A5_A5A5, '0));  // updates
    send_request(make_item(REQ_INS_OR_UPD, 32'd7,     32'h0000_0077, '0));  // inserts
    send_request(make_item(REQ_LOOKUP,     KEY_ONES,  '0,           '0));
    send_request(make_item(REQ_LOOKUP,     32'd9,     '0,           '0));
    send_request(make_item(REQ_READ_AT,    '0,        '0,           4'd2));
    send_request(make_item(REQ_READ_AT,    '0,        '0,           '1));  // out of range
    send_request(make_item(REQ_ERASE,      '0,        '0,           '0));  // shifts the rest
    send_request(make_item(REQ_ERASE,      32'd9,     '0,           '0));  // absent key
    send_request(make_item(REQ_SPARE_6,    KEY_ONES,  VAL_ONES,     '1));
    send_request(make_item(REQ_SPARE_7,    32'd7,     VAL_ONES,     4'd1));
    send_request(make_item(REQ_READ_AT,    '0,        '0,           4'd1));
  endtask

  // Lowered and clamped limits, including a limit below the current count.
  task automatic test_capacity_edges();
    set_capacity(5'd2);
    send_request(make_item(REQ_INSERT,     32'd3,    32'h3, '0));  // at the limit
    set_capacity(5'd1);
    send_request(make_item(REQ_INSERT,     32'd4,    32'h4, '0));  // count above limit
    send_request(make_item(REQ_INS_OR_UPD, 32'd7,    32'h8, '0));  // still updates
    send_request(make_item(REQ_INS_OR_UPD, 32'd11,   32'hB, '0));  // no room to insert
    set_capacity(5'd0);
    send_request(make_item(REQ_INSERT,     32'd12,   32'hC, '0));
    send_request(make_item(REQ_ERASE,      KEY_ONES, '0,    '0));
    send_request(make_item(REQ_ERASE,      32'd7,    '0,    '0));
    send_request(make_item(REQ_READ_AT,    '0,       '0,    '0));  // empty table
    set_capacity(5'd31);                                           // clamps to DEPTH
  endtask

  // Random traffic in phases that each combine an idling pattern with a capacity setting.
  task automatic test_random_traffic();
    int               idle_set  [5] = '{0, 64, 0, 38, 0};
    int               stall_set [5] = '{0, 0, 64, 38, 0};
    logic [CAP_W-1:0] cap_set   [5] = '{5'd16, 5'd5, 5'd31, 5'd0, 5'd12};
    for (int ph = 0; ph < 5; ph++) begin
      set_capacity(cap_set[ph]);
      refill_key_pool();
      send_idle_pct  = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_request(random_request());
    end
  endtask

  // Short bursts with the sender holding off until the block has answered everything.
  task automatic test_drain_pause();
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    set_capacity(5'd8);
    for (int b = 0; b < 10; b++) begin
      repeat ($urandom_range(1, 12)) send_request(random_request());
      drain_results();
      @(negedge clk);
    end
  endtask

  // Compare each accepted result, field by field, with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %p", out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.ok !== want.ok)
          report_mismatch($sformatf("ok %b, want %b", out_data.ok, want.ok));
        if (out_data.key_out !== want.key_out)
          report_mismatch($sformatf("key_out %h, want %h", out_data.key_out, want.key_out));
        if (out_data.value_out !== want.value_out)
          report_mismatch($sformatf("value_out %h, want %h",
                                    out_data.value_out, want.value_out));
        if (out_data.entry_total !== want.entry_total)
          report_mismatch($sformatf("entry_total %0d, want %0d",
                                    out_data.entry_total, want.entry_total));
        if (out_data.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty %b, want %b", out_data.is_empty, want.is_empty));
      end
    end
  end

  initial begin
    foreach (ops_sent[i]) ops_sent[i] = 0;
    foreach (shadow_keys[i]) begin
      shadow_keys[i] = '0;
      shadow_vals[i] = '0;
    end
    shadow_count = 0;
    shadow_cap   = CAP_RESET;

    // Hold reset, then release on a falling edge.
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_ops();
    test_capacity_edges();
    test_random_traffic();
    test_drain_pause();

    // Wait out the tail, then catch any result the block still produces.
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("Covered insert %0d, update %0d, insert_or_update %0d, erase %0d, lookup %0d,",
             ops_sent[REQ_INSERT], ops_sent[REQ_UPDATE], ops_sent[REQ_INS_OR_UPD],
             ops_sent[REQ_ERASE], ops_sent[REQ_LOOKUP]);
    $display("  read_at %0d, spare codes %0d; %0d results checked, %0d limit writes, %0d errors",
             ops_sent[REQ_READ_AT], ops_sent[REQ_SPARE_6] + ops_sent[REQ_SPARE_7],
             results_seen, cap_writes, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
